// File: design/arm_pkg.sv
// Shared types, codes and constants for the address region map.
package arm_pkg;

  localparam int ADDR_W = 48;
  localparam int DEFAULT_SLOTS = 64;
  // Wide enough for the largest supported slot count.
  localparam int IDX_W = 10;
  localparam int CNT_W_MAX = 11;
  localparam int SEARCH_TRIES = 100;
  localparam logic [ADDR_W-1:0] ADDR_MASK = 48'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] DEFAULT_HINT = 48'h0000_7000_0000;
  localparam logic [ADDR_W-1:0] SEARCH_STEP = 48'h0000_0010_0000;
  localparam logic [ADDR_W-1:0] RESET_LOWEST = 48'h0000_0001_0000;
  localparam logic [ADDR_W-1:0] RESET_HIGHEST = 48'h0000_7FFF_F000;

  localparam logic [2:0] CMD_SEARCH = 3'd0;
  localparam logic [2:0] CMD_FIXED = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_PROTECT = 3'd3;
  localparam logic [2:0] CMD_LOOKUP = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic CFG_LOWEST = 1'b0;
  localparam logic CFG_HIGHEST = 1'b1;

  typedef enum logic [1:0] {
    OP_SCAN,
    OP_REMOVE,
    OP_PROTECT,
    OP_LOOKUP
  } arm_op_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] address;
    logic [47:0] end_address;
    logic [47:0] length;
    logic [2:0]  protection;
    logic [15:0] map_flags;
    logic [47:0] object_offset;
    logic [15:0] object_id;
  } arm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] placed_address;
    logic [47:0] found_start;
    logic [47:0] found_end;
    logic [2:0]  found_protection;
    logic [15:0] found_flags;
    logic [47:0] found_offset;
    logic [15:0] found_object;
    logic [6:0]  region_total;
  } arm_rsp_t;

  // One stored region.
  typedef struct packed {
    logic [47:0] start;
    logic [47:0] stop;
    logic [2:0]  prot;
    logic [15:0] flags;
    logic [47:0] offset;
    logic [15:0] obj;
  } arm_rec_t;

  // What travels from cell to cell with the pass token.
  typedef struct packed {
    logic             tok;
    logic             ovl;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W_MAX-1:0] removed;
    logic             hit;
    arm_rec_t         hit_rec;
  } arm_acc_t;

  // Broadcast query seen by every cell.
  typedef struct packed {
    arm_op_t     op;
    logic [47:0] lo;
    logic [47:0] hi;
    logic [2:0]  prot;
  } arm_query_t;

endpackage

// File: design/arm_cell.sv
// One region slot of the chain: holds a region and updates the passing beat.
module arm_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  arm_pkg::arm_query_t      query,
  input  logic                     wr_en,
  input  logic [arm_pkg::IDX_W-1:0] wr_slot,
  input  arm_pkg::arm_rec_t        wr_rec,
  input  arm_pkg::arm_acc_t        acc_in,
  output arm_pkg::arm_acc_t        acc_out
);
  import arm_pkg::*;

  logic     valid;
  arm_rec_t rec;
  logic     ovl_hit;
  logic     inside_hit;
  logic     look_hit;
  arm_acc_t acc_next;

  // Range tests against the broadcast query.
  assign ovl_hit    = valid && (rec.start < query.hi) && (rec.stop > query.lo);
  assign inside_hit = valid && (rec.start >= query.lo) && (rec.stop <= query.hi);
  assign look_hit   = valid && (query.lo >= rec.start) && (query.lo < rec.stop);

  // Fold this slot into the beat that is passing through.
  always_comb begin
    acc_next = acc_in;
    if (acc_in.tok) begin
      case (query.op)
        OP_SCAN: begin
          acc_next.ovl = acc_in.ovl | ovl_hit;
          if (!acc_in.free_ok && !valid) begin
            acc_next.free_ok  = 1'b1;
            acc_next.free_idx = IDX_W'(IDX);
          end
        end
        OP_REMOVE: begin
          if (inside_hit) begin
            acc_next.removed = acc_in.removed + 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (!acc_in.hit && look_hit) begin
            acc_next.hit     = 1'b1;
            acc_next.hit_rec = rec;
          end
        end
        default: ;
      endcase
    end
  end

  // Hand the beat to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_out.tok <= 1'b0;
    end else begin
      acc_out.tok <= acc_next.tok;
    end
    acc_out.ovl      <= acc_next.ovl;
    acc_out.free_ok  <= acc_next.free_ok;
    acc_out.free_idx <= acc_next.free_idx;
    acc_out.removed  <= acc_next.removed;
    acc_out.hit      <= acc_next.hit;
    acc_out.hit_rec  <= acc_next.hit_rec;
  end

  // Slot state: insert, remove and protection updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en && wr_slot == IDX_W'(IDX)) begin
      valid <= 1'b1;
    end else if (acc_in.tok && query.op == OP_REMOVE && inside_hit) begin
      valid <= 1'b0;
    end
    if (wr_en && wr_slot == IDX_W'(IDX)) begin
      rec <= wr_rec;
    end else if (acc_in.tok && query.op == OP_PROTECT && ovl_hit) begin
      rec.prot <= query.prot;
    end
  end

endmodule

// File: design/address_region_map.sv
// Top level of the address region map: command sequencer and chain of slot cells.
//
//   channel   direction  handshake              beat
//   request   in         start & !busy          arm_req_t
//   result    out        done (one cycle)       arm_rsp_t
//   config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Every table access is a pass of a token down the chain of REGION_SLOTS cells,
// one cell a cycle. Lookup, remove, protect and fixed placement give done
// once the token leaves the last cell; size or alignment errors and unused
// commands give it from the decode state. A searched placement passes the token
// once per candidate, up to 100 candidates.
// Reset clears all slot valid bits at once; no sweep. The receiver cannot stall.
module address_region_map #(
  parameter int REGION_SLOTS = arm_pkg::DEFAULT_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  arm_pkg::arm_req_t request,
  output logic              done,
  output arm_pkg::arm_rsp_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [47:0]       cfg_data
);
  import arm_pkg::*;

  localparam int CNT_W = $clog2(REGION_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PREP,
    S_CHECK,
    S_PASS
  } state_t;

  state_t            state;
  arm_req_t          req;
  logic [48:0]       size;
  logic [49:0]       cand;
  logic [6:0]        tries;
  logic [CNT_W-1:0]  count;
  logic [47:0]       lowest;
  logic [47:0]       highest;
  arm_query_t        query;
  logic              launch;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_slot;
  arm_rec_t          wr_rec;
  arm_acc_t          chain [REGION_SLOTS+1];
  arm_acc_t          tail;
  logic [47:0]       hint;
  logic [49:0]       cand_first;
  logic [50:0]       cand_end;
  logic [49:0]       fixed_end;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign tail = chain[REGION_SLOTS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest  <= RESET_LOWEST;
      highest <= RESET_HIGHEST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LOWEST) begin
        lowest <= cfg_data;
      end else begin
        highest <= cfg_data;
      end
    end
  end

  // Candidate arithmetic for the search.
  always_comb begin
    hint = (req.address == '0) ? DEFAULT_HINT : req.address;
    if (hint < lowest) begin
      hint = lowest;
    end
    cand_first = ({2'b00, hint} + 50'hFFF) & ~50'hFFF;
    cand_end   = {1'b0, cand} + {2'b00, size};
    fixed_end  = {2'b00, req.address} + {1'b0, size};
  end

  // Token injection at the head of the chain.
  always_comb begin
    chain[0]     = '0;
    chain[0].tok = launch;
  end

  // Row of slot cells.
  for (genvar g = 0; g < REGION_SLOTS; g++) begin : g_cell
    arm_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .query   (query),
      .wr_en   (wr_en),
      .wr_slot (wr_slot),
      .wr_rec  (wr_rec),
      .acc_in  (chain[g]),
      .acc_out (chain[g+1])
    );
  end

  // Command sequencer with registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      launch <= 1'b0;
      wr_en  <= 1'b0;
      count  <= '0;
    end else begin
      done   <= 1'b0;
      launch <= 1'b0;
      wr_en  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req    <= request;
            size   <= ({1'b0, request.length} + 49'hFFF) & ~49'hFFF;
            result <= '0;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          query.prot <= req.protection;
          case (req.command) inside
            CMD_SEARCH: begin
              if (size == '0) begin
                result.status       <= ST_BAD_SIZE;
                result.region_total <= 7'(count);
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_PREP;
              end
            end
            CMD_FIXED: begin
              if (size == '0 || req.address[11:0] != 12'h000) begin
                result.status       <= ST_BAD_SIZE;
                result.region_total <= 7'(count);
                done  <= 1'b1;
                state <= S_IDLE;
              end else if (fixed_end > {2'b00, ADDR_MASK}) begin
                result.status       <= ST_NO_SPACE;
                result.region_total <= 7'(count);
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                query.op <= OP_SCAN;
                query.lo <= req.address;
                query.hi <= fixed_end[47:0];
                launch   <= 1'b1;
                state    <= S_PASS;
              end
            end
            CMD_REMOVE, CMD_PROTECT, CMD_LOOKUP: begin
              query.op <= (req.command == CMD_REMOVE) ? OP_REMOVE :
                          (req.command == CMD_PROTECT) ? OP_PROTECT : OP_LOOKUP;
              query.lo <= req.address;
              query.hi <= req.end_address;
              launch   <= 1'b1;
              state    <= S_PASS;
            end
            default: begin
              result.region_total <= 7'(count);
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_PREP: begin
          cand  <= cand_first;
          tries <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (tries < 7'(SEARCH_TRIES) && cand_end <= {3'b000, highest}) begin
            query.op <= OP_SCAN;
            query.lo <= cand[47:0];
            query.hi <= cand_end[47:0];
            launch   <= 1'b1;
            state    <= S_PASS;
          end else begin
            result.status       <= ST_NO_SPACE;
            result.region_total <= 7'(count);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PASS: begin
          if (tail.tok) begin
            case (query.op)
              OP_SCAN: begin
                if (tail.ovl && req.command == CMD_SEARCH) begin
                  cand  <= cand + {2'b00, SEARCH_STEP};
                  tries <= tries + 7'd1;
                  state <= S_CHECK;
                end else begin
                  state <= S_IDLE;
                  done  <= 1'b1;
                  if (tail.ovl) begin
                    result.status       <= ST_NO_SPACE;
                    result.region_total <= 7'(count);
                  end else if (!tail.free_ok) begin
                    result.status       <= ST_FULL;
                    result.region_total <= 7'(count);
                  end else begin
                    wr_en       <= 1'b1;
                    wr_slot     <= tail.free_idx;
                    wr_rec.start  <= query.lo;
                    wr_rec.stop   <= query.hi;
                    wr_rec.prot   <= req.protection;
                    wr_rec.flags  <= req.map_flags;
                    wr_rec.offset <= req.object_offset;
                    wr_rec.obj    <= req.object_id;
                    count <= count + 1'b1;
                    result.status         <= ST_OK;
                    result.placed_address <= query.lo;
                    result.region_total   <= 7'(count + 1'b1);
                  end
                end
              end
              OP_REMOVE: begin
                count <= count - tail.removed[CNT_W-1:0];
                result.region_total <= 7'(count - tail.removed[CNT_W-1:0]);
                done  <= 1'b1;
                state <= S_IDLE;
              end
              OP_LOOKUP: begin
                if (tail.hit) begin
                  result.found_start      <= tail.hit_rec.start;
                  result.found_end        <= tail.hit_rec.stop;
                  result.found_protection <= tail.hit_rec.prot;
                  result.found_flags      <= tail.hit_rec.flags;
                  result.found_offset     <= tail.hit_rec.offset;
                  result.found_object     <= tail.hit_rec.obj;
                end else begin
                  result.status <= ST_NOT_FOUND;
                end
                result.region_total <= 7'(count);
                done  <= 1'b1;
                state <= S_IDLE;
              end
              default: begin
                result.region_total <= 7'(count);
                done  <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/address_region_map_tb.sv
// Self-checking testbench for the address region map: random and directed commands.
module address_region_map_tb;
  import arm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int STALL_LIMIT = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  arm_req_t request;
  logic done;
  arm_rsp_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [47:0] cfg_data;

  address_region_map #(.REGION_SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted table contents and limits.
  logic        tbl_valid [SLOTS];
  arm_rec_t    tbl_rec [SLOTS];
  int          tbl_count;
  logic [47:0] min_base;
  logic [47:0] max_end;

  arm_req_t cmd_queue[$];
  arm_rsp_t expected_rsps[$];
  int mismatches;
  int stall_cycles;
  int send_idle_pct;

  // Write-channel request, serviced by the config driver.
  logic        cfg_pending;
  logic        cfg_req_index;
  logic [47:0] cfg_req_data;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit hits_any(logic [48:0] lo, logic [48:0] hi);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && {1'b0, tbl_rec[i].start} < hi && {1'b0, tbl_rec[i].stop} > lo)
        return 1'b1;
    return 1'b0;
  endfunction

  // Fixed placement into the predicted table; returns a status code.
  function automatic logic [2:0] insert_region(logic [47:0] base, logic [48:0] size,
                                                arm_req_t req);
    logic [48:0] top;
    top = {1'b0, base} + size;
    if (size == 0 || base[11:0] != 0) return ST_BAD_SIZE;
    if (top > {1'b0, ADDR_MASK}) return ST_NO_SPACE;
    if (hits_any({1'b0, base}, top)) return ST_NO_SPACE;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_rec[i] = '{start: base, stop: top[47:0], prot: req.protection,
                       flags: req.map_flags, offset: req.object_offset,
                       obj: req.object_id};
        tbl_count++;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  // Apply one command to the predicted table and return its result.
  function automatic arm_rsp_t apply_command(arm_req_t req);
    arm_rsp_t rsp;
    logic [48:0] size;
    logic [50:0] cand;
    bit got;
    rsp = '0;
    size = ({1'b0, req.length} + 49'hFFF) & ~49'hFFF;
    case (req.command)
      CMD_SEARCH: begin
        if (size == 0) begin
          rsp.status = ST_BAD_SIZE;
        end else begin
          cand = (req.address != 0) ? {3'b000, req.address} : {3'b000, DEFAULT_HINT};
          if (cand < {3'b000, min_base}) cand = {3'b000, min_base};
          cand = (cand + 51'hFFF) & ~51'hFFF;
          got = 1'b0;
          for (int t = 0; t < SEARCH_TRIES && cand + {2'b00, size} <= {3'b000, max_end};
               t++) begin
            if (!hits_any(cand[48:0], cand[48:0] + size)) begin
              got = 1'b1;
              break;
            end
            cand += {3'b000, SEARCH_STEP};
          end
          if (!got) begin
            rsp.status = ST_NO_SPACE;
          end else begin
            rsp.status = insert_region(cand[47:0], size, req);
            if (rsp.status == ST_OK) rsp.placed_address = cand[47:0];
          end
        end
      end
      CMD_FIXED: begin
        rsp.status = insert_region(req.address, size, req);
        if (rsp.status == ST_OK) rsp.placed_address = req.address;
      end
      CMD_REMOVE: begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && tbl_rec[i].start >= req.address
              && tbl_rec[i].stop <= req.end_address) begin
            tbl_valid[i] = 1'b0;
            tbl_count--;
          end
      end
      CMD_PROTECT: begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && tbl_rec[i].start < req.end_address
              && tbl_rec[i].stop > req.address)
            tbl_rec[i].prot = req.protection;
      end
      CMD_LOOKUP: begin
        rsp.status = ST_NOT_FOUND;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && req.address >= tbl_rec[i].start
              && req.address < tbl_rec[i].stop) begin
            rsp.status = ST_OK;
            rsp.found_start = tbl_rec[i].start;
            rsp.found_end = tbl_rec[i].stop;
            rsp.found_protection = tbl_rec[i].prot;
            rsp.found_flags = tbl_rec[i].flags;
            rsp.found_offset = tbl_rec[i].offset;
            rsp.found_object = tbl_rec[i].obj;
            break;
          end
        end
      end
      default: ;
    endcase
    rsp.region_total = tbl_count[6:0];
    return rsp;
  endfunction

  // Driver: offers queued commands, idling at random between beats.
  // The offered command stays at the front of the queue until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_rsps.push_back(apply_command(request));
        void'(cmd_queue.pop_front());
      end
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        request <= cmd_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", result);
      end else begin
        arm_rsp_t want;
        want = expected_rsps.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  // Config driver: holds one register write until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      cfg_index <= CFG_LOWEST;
      cfg_data <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      cfg_pending <= 1'b0;
    end else if (cfg_pending && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_req_index;
      cfg_data <= cfg_req_data;
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL address_region_map");
      $finish;
    end
  end

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || start || expected_rsps.size() != 0) @(posedge clk);
    repeat (SLOTS * SEARCH_TRIES / 8 + 20) @(posedge clk);
  endtask

  task automatic write_limit(logic idx, logic [47:0] value);
    wait_idle();
    cfg_req_index = idx;
    cfg_req_data = value;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
    if (idx == CFG_LOWEST) min_base = value;
    else max_end = value;
  endtask

  function automatic arm_req_t make_cmd(logic [2:0] op, logic [47:0] a, logic [47:0] e,
                                        logic [47:0] len);
    arm_req_t r;
    r.command = op;
    r.address = a;
    r.end_address = e;
    r.length = len;
    r.protection = 3'($urandom_range(7));
    r.map_flags = 16'($urandom);
    r.object_offset = 48'({$urandom, $urandom});
    r.object_id = 16'($urandom);
    return r;
  endfunction

  function automatic logic [47:0] rand_wide();
    return 48'({$urandom, $urandom});
  endfunction

  // Random command biased toward a small window so regions collide often.
  function automatic arm_req_t rand_cmd();
    logic [47:0] a;
    logic [47:0] len;
    int pick;
    pick = $urandom_range(99);
    a = 48'h7000_0000 + 48'($urandom_range(400) << 12);
    if ($urandom_range(9) == 0) a = rand_wide();
    else if ($urandom_range(9) == 0) a = a + 48'($urandom_range(4095));
    len = $urandom_range(9) == 0 ? rand_wide() : 48'($urandom_range(1, 3 << 20));
    if ($urandom_range(30) == 0) len = 0;
    if (pick < 25) return make_cmd(CMD_SEARCH, $urandom_range(3) == 0 ? 48'h0 : a, 0, len);
    if (pick < 45) return make_cmd(CMD_FIXED, a & ~48'hFFF, 0, len);
    if (pick < 55) return make_cmd(CMD_REMOVE, a, a + 48'($urandom_range(64) << 16), 0);
    if (pick < 65) return make_cmd(CMD_PROTECT, a, a + 48'($urandom_range(64) << 16), 0);
    if (pick < 97) return make_cmd(CMD_LOOKUP, a + 48'($urandom_range(1 << 20)), 0, 0);
    return make_cmd(3'($urandom_range(5, 7)), a, rand_wide(), len);
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LOWEST;
    cfg_data = '0;
    cfg_pending = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    send_idle_pct = 30;
    min_base = RESET_LOWEST;
    max_end = RESET_HIGHEST;
    tbl_count = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every command, rounding and misalignment cases.
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 0, 1));
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 0, 48'h2000));
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 48'h5, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 48'h7000_0001, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_SEARCH, ADDR_MASK, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_FIXED, 48'h1234, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_FIXED, 48'h1000, 0, ADDR_MASK));
    cmd_queue.push_back(make_cmd(CMD_FIXED, 48'hFFFF_FFFF_E000, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_FIXED, 48'hFFFF_FFFF_F000, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_FIXED, 48'h0, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_FIXED, 48'h7000_0000, 0, 48'h1000));
    cmd_queue.push_back(make_cmd(CMD_LOOKUP, 48'h7000_0FFF, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_LOOKUP, 48'hFFFF_FFFF_EFFF, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_LOOKUP, 48'h0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_PROTECT, 48'h0, ADDR_MASK, 0));
    cmd_queue.push_back(make_cmd(CMD_PROTECT, ADDR_MASK, 48'h0, 0));
    cmd_queue.push_back(make_cmd(CMD_LOOKUP, 48'h10, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_REMOVE, ADDR_MASK, 48'h0, 0));
    cmd_queue.push_back(make_cmd(3'd7, ADDR_MASK, ADDR_MASK, ADDR_MASK));
    cmd_queue.push_back(make_cmd(CMD_REMOVE, 48'h0, ADDR_MASK, 0));
    // Fill the table to reach the full case.
    for (int i = 0; i < SLOTS + 2; i++)
      cmd_queue.push_back(make_cmd(CMD_FIXED, 48'h1000_0000 + 48'(i << 12), 0, 1));
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 0, 1));
    cmd_queue.push_back(make_cmd(CMD_REMOVE, 48'h0, ADDR_MASK, 0));

    // Narrow window: search runs out of room after a few steps.
    write_limit(CFG_LOWEST, 48'h7000_0800);
    write_limit(CFG_HIGHEST, 48'h7030_0000);
    for (int i = 0; i < 8; i++) cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 0, 48'h10_0000));
    write_limit(CFG_LOWEST, ADDR_MASK);
    write_limit(CFG_HIGHEST, ADDR_MASK);
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 0, 1));
    write_limit(CFG_LOWEST, 48'h0);
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 48'h7000_0000, 0, 1));
    write_limit(CFG_HIGHEST, 48'h0);
    cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 0, 1));

    // Random phases, each with its own limits and idling pattern.
    for (int ph = 0; ph < 3; ph++) begin
      write_limit(CFG_LOWEST, ph == 2 ? 48'h0 : 48'h10000 << ph);
      write_limit(CFG_HIGHEST, ph == 1 ? 48'h7400_0000 : RESET_HIGHEST);
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 56 : 0;
      for (int i = 0; i < 200; i++) begin
        cmd_queue.push_back(rand_cmd());
        if (cmd_queue.size() > 8) @(posedge clk);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS address_region_map");
    end else begin
      $display("FAIL address_region_map");
    end
    $finish;
  end
endmodule

// File: files.f
design/arm_pkg.sv
design/arm_cell.sv
design/address_region_map.sv
test/address_region_map_tb.sv
